// ===== design/kus_pkg.sv =====
// ----------------------------------------------------------------------------
// kus_pkg
// Types and codes shared by the keyed unique stack and its cells.
// ----------------------------------------------------------------------------
package kus_pkg;

   localparam int KEY_W    = 16;
   localparam int RECORD_W = 32;
   localparam int KIND_W   = 3;
   localparam int STATUS_W = 3;
   localparam int COUNT_W  = 5;

   // operation codes carried in the kind field
   localparam logic [KIND_W-1:0] KIND_PUSH   = 3'd0;
   localparam logic [KIND_W-1:0] KIND_POP    = 3'd1;
   localparam logic [KIND_W-1:0] KIND_PEEK   = 3'd2;
   localparam logic [KIND_W-1:0] KIND_FIND   = 3'd3;
   localparam logic [KIND_W-1:0] KIND_REMOVE = 3'd4;

   // result status codes
   localparam logic [STATUS_W-1:0] STATUS_OK      = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_DUP     = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL    = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY   = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_MISSING = 3'd4;

   typedef struct packed {
      logic [KIND_W-1:0]   kind;
      logic [KEY_W-1:0]    key;
      logic [RECORD_W-1:0] record;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [KEY_W-1:0]    found_key;
      logic [RECORD_W-1:0] found_record;
      logic [COUNT_W-1:0]  fill_count;
   } rsp_type;

   // what every cell does this cycle
   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_MARK_TOP,
      CELL_MARK_KEY,
      CELL_PUSH,
      CELL_SHIFT
   } cell_op_type;

   typedef struct packed {
      cell_op_type         op;
      logic [KEY_W-1:0]    key;
      logic [RECORD_W-1:0] record;
   } cell_ctl_type;

   typedef enum logic [1:0] {
      STATE_IDLE,
      STATE_RESOLVE,
      STATE_APPLY
   } state_type;

endpackage

// ===== design/kus_cell.sv =====
// ----------------------------------------------------------------------------
// kus_cell
// One stack slot: key and record, a local key compare and a shift-down path.
// ----------------------------------------------------------------------------
module kus_cell #(
   parameter int DEPTH = 16,
   parameter int INDEX = 0
) (
   input  logic                          clock,
   input  logic                          reset,
   input  kus_pkg::cell_ctl_type         ctl,
   input  logic [$clog2(DEPTH+1)-1:0]    fill,
   input  logic [$clog2(DEPTH)-1:0]      slot,
   input  logic [kus_pkg::KEY_W-1:0]     up_key,
   input  logic [kus_pkg::RECORD_W-1:0]  up_record,
   output logic [kus_pkg::KEY_W-1:0]     key,
   output logic [kus_pkg::RECORD_W-1:0]  record,
   output logic                          sel
);

   localparam int LW = $clog2(DEPTH+1);
   localparam int IW = $clog2(DEPTH);

   localparam logic [LW-1:0] POS      = LW'(INDEX);
   localparam logic [LW-1:0] POS_NEXT = LW'(INDEX + 1);
   localparam logic [IW-1:0] POS_SLOT = IW'(INDEX);

   logic [kus_pkg::KEY_W-1:0]    key_ff, key_in;
   logic [kus_pkg::RECORD_W-1:0] record_ff, record_in;
   logic                         sel_ff, sel_in;
   logic                         occupied;

   assign occupied = (POS < fill);

   always_comb begin
      key_in    = key_ff;
      record_in = record_ff;
      sel_in    = sel_ff;
      case (ctl.op)
         kus_pkg::CELL_MARK_TOP: sel_in = (POS_NEXT == fill);
         kus_pkg::CELL_MARK_KEY: sel_in = occupied && (key_ff == ctl.key);
         kus_pkg::CELL_PUSH: begin
            if (POS == fill) begin
               key_in    = ctl.key;
               record_in = ctl.record;
            end
         end
         kus_pkg::CELL_SHIFT: begin
            // everything at or above the removed slot moves down one
            if (POS_SLOT >= slot) begin
               key_in    = up_key;
               record_in = up_record;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      key_ff    <= key_in;
      record_ff <= record_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sel_ff <= 1'b0;
      end else begin
         sel_ff <= sel_in;
      end
   end

   assign key    = key_ff;
   assign record = record_ff;
   assign sel    = sel_ff;

endmodule

// ===== design/kus_select.sv =====
// ----------------------------------------------------------------------------
// kus_select
// Collapses the one-hot cell marks into hit, slot index and entry contents.
// ----------------------------------------------------------------------------
module kus_select #(
   parameter int DEPTH = 16
) (
   input  logic [DEPTH-1:0]              sel,
   input  logic [kus_pkg::KEY_W-1:0]     keys    [DEPTH],
   input  logic [kus_pkg::RECORD_W-1:0]  records [DEPTH],
   output logic                          hit,
   output logic [$clog2(DEPTH)-1:0]      slot,
   output logic [kus_pkg::KEY_W-1:0]     key,
   output logic [kus_pkg::RECORD_W-1:0]  record
);

   localparam int IW = $clog2(DEPTH);

   // keys are unique, so at most one mark is set: a plain AND-OR will do
   always_comb begin
      hit    = |sel;
      slot   = '0;
      key    = '0;
      record = '0;
      for (int i = 0; i < DEPTH; i++) begin
         slot   = slot   | ({IW{sel[i]}} & IW'(i));
         key    = key    | ({kus_pkg::KEY_W{sel[i]}} & keys[i]);
         record = record | ({kus_pkg::RECORD_W{sel[i]}} & records[i]);
      end
   end

endmodule

// ===== design/keyed_unique_stack.sv =====
// ----------------------------------------------------------------------------
// keyed_unique_stack
// Bounded LIFO of key/record entries with unique keys, built as a cell chain.
// ----------------------------------------------------------------------------
// Usage:
//   req channel carries one command transaction (kind, key, record); kinds
//   are push, pop, peek, find and remove by key. rsp channel returns exactly
//   one transaction per command: status, found key/record and fill count.
//   Each command passes through three steps: all cells compare in parallel,
//   the one-hot marks are collapsed into hit/slot/data, then the cells are
//   updated. A new command is taken only after the previous one has been
//   through its update step. req_stall is high while a command is in flight.
//   The response sits in an output register, so a new command is taken while
//   the previous response is still stalled; the update step only waits if
//   that register still holds a response whose transaction is stalled when
//   the next one is ready. Reset (synchronous, active high) empties the
//   stack. Slot contents are not cleared; only slots below the fill level
//   are ever read.
//   fill_count reports the low 5 bits of the fill level.
// ----------------------------------------------------------------------------
module keyed_unique_stack #(
   parameter int DEPTH = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  kus_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output kus_pkg::rsp_type rsp_data
);

   localparam int LW = $clog2(DEPTH+1);
   localparam int IW = $clog2(DEPTH);

   // slot 0 is the bottom; cell fill-1 is the top
   logic [kus_pkg::KEY_W-1:0]    cell_key    [DEPTH];
   logic [kus_pkg::RECORD_W-1:0] cell_record [DEPTH];
   logic [DEPTH-1:0]             cell_sel;

   kus_pkg::state_type    state_ff, state_in;
   kus_pkg::req_type      req_ff, req_in;
   kus_pkg::cell_ctl_type ctl;
   logic [LW-1:0]         fill_ff, fill_in;

   // resolved search result
   logic                         hit, hit_ff;
   logic [IW-1:0]                slot, slot_ff;
   logic [kus_pkg::KEY_W-1:0]    sel_key, sel_key_ff;
   logic [kus_pkg::RECORD_W-1:0] sel_record, sel_record_ff;

   logic             rsp_valid_ff, rsp_valid_in;
   kus_pkg::rsp_type rsp_ff, rsp_in;
   logic             out_free;
   logic             full;
   logic [31:0]      fill_wide;

   // ---- cell chain ----
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      localparam int UP = (i == DEPTH - 1) ? i : i + 1;
      kus_cell #(
         .DEPTH (DEPTH),
         .INDEX (i)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctl       (ctl),
         .fill      (fill_ff),
         .slot      (slot_ff),
         .up_key    (cell_key[UP]),
         .up_record (cell_record[UP]),
         .key       (cell_key[i]),
         .record    (cell_record[i]),
         .sel       (cell_sel[i])
      );
   end

   kus_select #(
      .DEPTH (DEPTH)
   ) u_select (
      .sel     (cell_sel),
      .keys    (cell_key),
      .records (cell_record),
      .hit     (hit),
      .slot    (slot),
      .key     (sel_key),
      .record  (sel_record)
   );

   assign full      = (fill_ff >= LW'(DEPTH));
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != kus_pkg::STATE_IDLE);

   // ---- sequencer ----
   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      fill_in      = fill_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      fill_wide    = '0;
      ctl.op       = kus_pkg::CELL_HOLD;
      ctl.key      = req_ff.key;
      ctl.record   = req_ff.record;

      unique case (state_ff)
         kus_pkg::STATE_IDLE: begin
            // cells compare straight off the incoming transaction
            ctl.key = req_data.key;
            if (req_valid) begin
               req_in   = req_data;
               state_in = kus_pkg::STATE_RESOLVE;
               if (req_data.kind == kus_pkg::KIND_POP ||
                   req_data.kind == kus_pkg::KIND_PEEK) begin
                  ctl.op = kus_pkg::CELL_MARK_TOP;
               end else begin
                  ctl.op = kus_pkg::CELL_MARK_KEY;
               end
            end
         end
         kus_pkg::STATE_RESOLVE: begin
            state_in = kus_pkg::STATE_APPLY;
         end
         kus_pkg::STATE_APPLY: begin
            if (out_free) begin
               state_in            = kus_pkg::STATE_IDLE;
               rsp_valid_in        = 1'b1;
               rsp_in.status       = kus_pkg::STATUS_OK;
               rsp_in.found_key    = '0;
               rsp_in.found_record = '0;
               case (req_ff.kind) inside
                  kus_pkg::KIND_PUSH: begin
                     if (hit_ff) begin
                        rsp_in.status = kus_pkg::STATUS_DUP;
                     end else if (full) begin
                        rsp_in.status = kus_pkg::STATUS_FULL;
                     end else begin
                        ctl.op  = kus_pkg::CELL_PUSH;
                        fill_in = fill_ff + LW'(1);
                     end
                  end
                  kus_pkg::KIND_POP, kus_pkg::KIND_PEEK: begin
                     if (!hit_ff) begin
                        rsp_in.status = kus_pkg::STATUS_EMPTY;
                     end else begin
                        rsp_in.found_key    = sel_key_ff;
                        rsp_in.found_record = sel_record_ff;
                        if (req_ff.kind == kus_pkg::KIND_POP) begin
                           fill_in = fill_ff - LW'(1);
                        end
                     end
                  end
                  kus_pkg::KIND_FIND, kus_pkg::KIND_REMOVE: begin
                     if (!hit_ff) begin
                        rsp_in.status = kus_pkg::STATUS_MISSING;
                     end else begin
                        rsp_in.found_key    = sel_key_ff;
                        rsp_in.found_record = sel_record_ff;
                        if (req_ff.kind == kus_pkg::KIND_REMOVE) begin
                           ctl.op  = kus_pkg::CELL_SHIFT;
                           fill_in = fill_ff - LW'(1);
                        end
                     end
                  end
                  default: ;   // unused kinds: ok, nothing changes
               endcase
               fill_wide         = 32'(fill_in);
               rsp_in.fill_count = fill_wide[kus_pkg::COUNT_W-1:0];
            end
         end
         default: state_in = kus_pkg::STATE_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= kus_pkg::STATE_IDLE;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff        <= req_in;
      rsp_ff        <= rsp_in;
      hit_ff        <= hit;
      slot_ff       <= slot;
      sel_key_ff    <= sel_key;
      sel_record_ff <= sel_record;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for keyed_unique_stack. A tracker keeps its own copy of
// the stack, predicts the response to every accepted command and compares
// each response field by field. A directed opening covers the empty, full,
// duplicate and unused-kind cases. A long random run with a drifting target
// fill level follows, with bursty traffic and a patterned response stall.
// ----------------------------------------------------------------------------
module testbench;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int STACK_DEPTH     = 16;
   localparam int RANDOM_COMMANDS = 1350;
   localparam int DRAIN_EVERY     = 450;   // sender waits until no response is owed
   localparam int IDLE_LIMIT      = 3000;  // cycles without any transaction
   localparam int REPORT_LIMIT    = 10;
   localparam int POOL_SIZE       = 32;

   // kind codes the block must ignore
   localparam logic [kus_pkg::KIND_W-1:0] KIND_UNUSED_LO = 3'd5;
   localparam logic [kus_pkg::KIND_W-1:0] KIND_UNUSED_HI = 3'd7;

   // response stall behavior, one per segment
   typedef enum int {
      FLOW_FREE,
      FLOW_LIGHT,
      FLOW_HEAVY,
      FLOW_PULSED
   } flow_mode_type;

   // -------------------------------------------------------------------------
   // Tracker: mirror of the stack contents plus the responses still owed.
   // -------------------------------------------------------------------------
   class key_stack_tracker;
      logic [kus_pkg::KEY_W-1:0]    keys    [STACK_DEPTH];
      logic [kus_pkg::RECORD_W-1:0] records [STACK_DEPTH];
      int                           level;
      kus_pkg::rsp_type             awaited_answers [$];
      int                           failures;

      function new();
         level    = 0;
         failures = 0;
      endfunction

      // topmost slot holding k, or -1
      function int locate(logic [kus_pkg::KEY_W-1:0] k);
         for (int i = level - 1; i >= 0; i--) begin
            if (keys[i] == k) return i;
         end
         return -1;
      endfunction

      function logic [kus_pkg::KEY_W-1:0] any_stored_key();
         return keys[$urandom_range(level - 1, 0)];
      endfunction

      // apply one accepted command and queue the response it must produce
      function void note_command(kus_pkg::req_type c);
         kus_pkg::rsp_type answer;
         int               slot;
         answer        = '0;
         answer.status = kus_pkg::STATUS_OK;
         case (c.kind) inside
            kus_pkg::KIND_PUSH: begin
               // duplicate check wins over full
               if (locate(c.key) >= 0) begin
                  answer.status = kus_pkg::STATUS_DUP;
               end else if (level >= STACK_DEPTH) begin
                  answer.status = kus_pkg::STATUS_FULL;
               end else begin
                  keys[level]    = c.key;
                  records[level] = c.record;
                  level++;
               end
            end
            kus_pkg::KIND_POP, kus_pkg::KIND_PEEK: begin
               if (level == 0) begin
                  answer.status = kus_pkg::STATUS_EMPTY;
               end else begin
                  answer.found_key    = keys[level - 1];
                  answer.found_record = records[level - 1];
                  if (c.kind == kus_pkg::KIND_POP) level--;
               end
            end
            kus_pkg::KIND_FIND, kus_pkg::KIND_REMOVE: begin
               slot = locate(c.key);
               if (slot < 0) begin
                  answer.status = kus_pkg::STATUS_MISSING;
               end else begin
                  answer.found_key    = keys[slot];
                  answer.found_record = records[slot];
                  if (c.kind == kus_pkg::KIND_REMOVE) begin
                     // close the gap, order of the others kept
                     for (int i = slot; i < level - 1; i++) begin
                        keys[i]    = keys[i + 1];
                        records[i] = records[i + 1];
                     end
                     level--;
                  end
               end
            end
            default: ;
         endcase
         answer.fill_count = kus_pkg::COUNT_W'(level);
         awaited_answers.push_back(answer);
      endfunction

      function void check_answer(kus_pkg::rsp_type got);
         kus_pkg::rsp_type want;
         if (awaited_answers.size() == 0) begin
            failures++;
            if (failures <= REPORT_LIMIT)
               $display("unexpected response: status %0d key %h record %h count %0d",
                        got.status, got.found_key, got.found_record, got.fill_count);
            return;
         end
         want = awaited_answers.pop_front();
         if (got.status !== want.status || got.found_key !== want.found_key ||
             got.found_record !== want.found_record ||
             got.fill_count !== want.fill_count) begin
            failures++;
            if (failures <= REPORT_LIMIT) begin
               $write("mismatch: expected status %0d key %h record %h count %0d,",
                      want.status, want.found_key, want.found_record, want.fill_count);
               $display(" got status %0d key %h record %h count %0d",
                        got.status, got.found_key, got.found_record, got.fill_count);
            end
         end
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Signals and block under test
   // -------------------------------------------------------------------------
   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   kus_pkg::req_type req_data  = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   kus_pkg::rsp_type rsp_data;

   key_stack_tracker tracker = new();

   // keys shared by pushes, finds and removes so that hits are common
   logic [kus_pkg::KEY_W-1:0] key_pool [POOL_SIZE];

   keyed_unique_stack #(
      .DEPTH(STACK_DEPTH)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // 20 ns period
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // -------------------------------------------------------------------------
   // Response side: stall follows segments of random length, each with its
   // own behavior, including stretches with no stall at all.
   // -------------------------------------------------------------------------
   int            stall_left = 0;
   flow_mode_type stall_mode = FLOW_FREE;

   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_mode = flow_mode_type'($urandom_range(3, 0));
         stall_left = $urandom_range(60, 8);
      end
      stall_left--;
      case (stall_mode)
         FLOW_FREE:  rsp_stall <= 1'b0;
         FLOW_LIGHT: rsp_stall <= ($urandom_range(3, 0) == 0);
         FLOW_HEAVY: rsp_stall <= ($urandom_range(3, 0) != 0);
         default:    rsp_stall <= stall_left[2];
      endcase
   end

   // every accepted response transaction is checked against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) tracker.check_answer(rsp_data);
   end

   // watchdog: too long without any transaction on either channel
   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles = 0;
         else idle_cycles++;
      end
      $display("Regression FAIL");
      $finish;
   end

   // -------------------------------------------------------------------------
   // Command side
   // -------------------------------------------------------------------------
   function automatic kus_pkg::req_type make_command(
      logic [kus_pkg::KIND_W-1:0]   kind,
      logic [kus_pkg::KEY_W-1:0]    key,
      logic [kus_pkg::RECORD_W-1:0] record);
      kus_pkg::req_type c;
      c.kind   = kind;
      c.key    = key;
      c.record = record;
      return c;
   endfunction

   // present one command at the falling edge and hold it until accepted;
   // valid stays high so back-to-back commands form a burst
   task automatic send_command(input kus_pkg::req_type c);
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= c;
      do @(posedge clock); while (req_stall !== 1'b0);
      tracker.note_command(c);
   endtask

   task automatic idle_sender(input int cycles);
      @(negedge clock);
      req_valid <= 1'b0;
      repeat (cycles - 1) @(negedge clock);
   endtask

   task automatic wait_until_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (tracker.awaited_answers.size() != 0) @(posedge clock);
   endtask

   // growing: mostly pushes; shrinking: mostly pops and removes
   function automatic logic [kus_pkg::KIND_W-1:0] pick_kind(bit grow);
      int roll;
      roll = $urandom_range(99, 0);
      if (grow) begin
         if (roll < 55) return kus_pkg::KIND_PUSH;
         if (roll < 65) return kus_pkg::KIND_POP;
         if (roll < 75) return kus_pkg::KIND_PEEK;
         if (roll < 88) return kus_pkg::KIND_FIND;
         return kus_pkg::KIND_REMOVE;
      end
      if (roll < 15) return kus_pkg::KIND_PUSH;
      if (roll < 45) return kus_pkg::KIND_POP;
      if (roll < 58) return kus_pkg::KIND_PEEK;
      if (roll < 72) return kus_pkg::KIND_FIND;
      return kus_pkg::KIND_REMOVE;
   endfunction

   // push leans on fresh pool keys, find/remove on keys already stored
   function automatic logic [kus_pkg::KEY_W-1:0] pick_key(
      logic [kus_pkg::KIND_W-1:0] kind);
      int roll;
      int stored_cut;
      int pool_cut;
      roll = $urandom_range(99, 0);
      if (kind == kus_pkg::KIND_PUSH) begin
         pool_cut   = 70;
         stored_cut = 88;
      end else if (kind == kus_pkg::KIND_FIND || kind == kus_pkg::KIND_REMOVE) begin
         stored_cut = 60;
         pool_cut   = 90;
      end else begin
         return kus_pkg::KEY_W'($urandom());
      end
      if (kind == kus_pkg::KIND_PUSH && roll < pool_cut)
         return key_pool[$urandom_range(POOL_SIZE - 1, 0)];
      if (roll < stored_cut && tracker.level > 0) return tracker.any_stored_key();
      if (roll < pool_cut || roll < stored_cut)
         return key_pool[$urandom_range(POOL_SIZE - 1, 0)];
      return kus_pkg::KEY_W'($urandom());
   endfunction

   // empty answers, ignored kinds, extreme values, full and duplicate-at-full
   task automatic run_directed();
      logic [kus_pkg::RECORD_W-1:0] all_ones;
      all_ones = '1;
      send_command(make_command(kus_pkg::KIND_POP,    16'hFFFF, all_ones));
      send_command(make_command(kus_pkg::KIND_PEEK,   16'h0000, 32'h0));
      send_command(make_command(kus_pkg::KIND_FIND,   16'h0000, 32'h0));
      send_command(make_command(kus_pkg::KIND_REMOVE, 16'hFFFF, all_ones));
      send_command(make_command(KIND_UNUSED_LO, 16'h0000, 32'h0));
      send_command(make_command(KIND_UNUSED_HI, 16'hFFFF, all_ones));
      // fill to the top, extremes at the bottom
      send_command(make_command(kus_pkg::KIND_PUSH, 16'h0000, 32'h0));
      send_command(make_command(kus_pkg::KIND_PUSH, 16'hFFFF, all_ones));
      for (int i = 2; i < STACK_DEPTH; i++)
         send_command(make_command(kus_pkg::KIND_PUSH, kus_pkg::KEY_W'(i * 16'h0F0F),
                                   $urandom()));
      send_command(make_command(kus_pkg::KIND_PUSH, 16'h8001, $urandom()));   // full
      send_command(make_command(kus_pkg::KIND_PUSH, 16'hFFFF, $urandom()));   // dup beats full
      send_command(make_command(kus_pkg::KIND_FIND, 16'h0000, 32'h0));        // deepest hit
      send_command(make_command(kus_pkg::KIND_REMOVE, kus_pkg::KEY_W'(7 * 16'h0F0F), 32'h0));
      send_command(make_command(kus_pkg::KIND_PEEK, 16'h0000, 32'h0));
      send_command(make_command(kus_pkg::KIND_POP,  16'h0000, 32'h0));
   endtask

   // random traffic; the target fill level drifts so the stack keeps swinging
   // between empty and full. Ignored kinds are sprinkled in as noise.
   task automatic run_random(input int total);
      kus_pkg::req_type c;
      int               counted;
      int               burst_left;
      int               target;
      bit               drain_now;
      counted    = 0;
      burst_left = $urandom_range(40, 1);
      target     = $urandom_range(STACK_DEPTH, 0);
      while (counted < total) begin
         drain_now = 1'b0;
         if ($urandom_range(39, 0) == 0) begin
            case ($urandom_range(3, 0))
               0:       target = 0;
               1:       target = STACK_DEPTH;
               default: target = $urandom_range(STACK_DEPTH, 0);
            endcase
         end
         c.record = $urandom();
         if ($urandom_range(99, 0) < 3) begin
            c.kind = kus_pkg::KIND_W'($urandom_range(KIND_UNUSED_HI, KIND_UNUSED_LO));
            c.key  = kus_pkg::KEY_W'($urandom());
         end else begin
            c.kind = pick_kind(tracker.level < target);
            c.key  = pick_key(c.kind);
            counted++;
            drain_now = (counted % DRAIN_EVERY == 0);
         end
         send_command(c);
         if (drain_now) wait_until_drained();
         burst_left--;
         if (burst_left == 0) begin
            if ($urandom_range(3, 0) != 0) idle_sender($urandom_range(12, 1));
            burst_left = $urandom_range(40, 1);
         end
      end
   endtask

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin
      key_pool[0] = '0;
      key_pool[1] = '1;
      for (int i = 2; i < POOL_SIZE; i++) key_pool[i] = kus_pkg::KEY_W'($urandom());

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      run_directed();
      wait_until_drained();
      run_random(RANDOM_COMMANDS);
      wait_until_drained();
      // keep the clock running to catch any stray response
      repeat (8) @(posedge clock);

      if (tracker.failures == 0 && tracker.awaited_answers.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
